[hdl/aes128_pkg.sv]
package aes128_pkg;

   localparam int ROUNDS = 10;
   localparam int CNT_W  = $clog2(ROUNDS + 1);

   typedef logic [127:0]            block_type;
   typedef logic [0:ROUNDS][127:0]  rk_array_type;

   // CSR map: one 64-bit register every 8 bytes
   localparam logic REG_KEY_HIGH = 1'b0;
   localparam logic REG_KEY_LOW  = 1'b1;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] POLY_LOW   = 8'h1b;

   localparam logic [0:255][7:0] FWD_SBOX = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [0:255][7:0] INV_SBOX = {
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
   endfunction

   function automatic block_type sub_bytes(input block_type s, input logic inv);
      block_type t;
      t = '0;
      for (int k = 0; k < 16; k++) begin
         t[127-8*k -: 8] = inv ? INV_SBOX[s[127-8*k -: 8]] : FWD_SBOX[s[127-8*k -: 8]];
      end
      return t;
   endfunction

   function automatic block_type shift_rows(input block_type s, input logic inv);
      block_type  t;
      logic [1:0] src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? 2'(c - r) : 2'(c + r);
            t[127-8*(4*c+r) -: 8] = s[127-8*(4*int'(src)+r) -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
      logic [3:0][7:0] a, x2, x4, x8, m9, m11, m13, m14, b;
      for (int k = 0; k < 4; k++) begin
         a[k]   = col[31-8*k -: 8];
         x2[k]  = xtime(a[k]);
         x4[k]  = xtime(x2[k]);
         x8[k]  = xtime(x4[k]);
         m9[k]  = x8[k] ^ a[k];
         m11[k] = x8[k] ^ x2[k] ^ a[k];
         m13[k] = x8[k] ^ x4[k] ^ a[k];
         m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      if (inv) begin
         b[0] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
         b[1] = m9[0]  ^ m14[1] ^ m11[2] ^ m13[3];
         b[2] = m13[0] ^ m9[1]  ^ m14[2] ^ m11[3];
         b[3] = m11[0] ^ m13[1] ^ m9[2]  ^ m14[3];
      end else begin
         b[0] = x2[0] ^ x2[1] ^ a[1] ^ a[2] ^ a[3];
         b[1] = a[0] ^ x2[1] ^ x2[2] ^ a[2] ^ a[3];
         b[2] = a[0] ^ a[1] ^ x2[2] ^ x2[3] ^ a[3];
         b[3] = x2[0] ^ a[0] ^ a[1] ^ a[2] ^ x2[3];
      end
      return {b[0], b[1], b[2], b[3]};
   endfunction

   function automatic block_type mix_columns(input block_type s, input logic inv);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
      end
      return t;
   endfunction

endpackage

[hdl/aes128_if.sv]
interface aes128_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] data_high;
   logic [63:0] data_low;

   modport source (output valid, output op, output data_high, output data_low, input ready);
   modport sink   (input valid, input op, input data_high, input data_low, output ready);
endinterface

interface aes128_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;

   modport source (output valid, output result_high, output result_low, input ready);
   modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

[hdl/aes128_block_cipher_core.sv]
// AES-128 ECB core, encrypt or decrypt one 128-bit word per unstalled cycle.
// req_chan carries op (0 encrypt, 1 decrypt) and the block as data_high
// (bytes 0..7) and data_low (bytes 8..15); rsp_chan returns the result in
// the same byte order. A word moves when valid and ready are both high.
// The CSR port holds the key: key_high at byte address 0, key_low at 8.
// Writing either register restarts the key expansion.
// Pipeline: initial key-add stage, then one cell per round, 11 register
// stages in all; rsp valid comes from the last cell's register.
// Throughput: one word per cycle when not stalled, set by the cell chain.
// Key expansion latches the key, then makes one round key per cycle:
// req_chan.ready stays low in a key write cycle and while the expansion is
// busy after that write or after reset falls.
// Reset clears the key to zero, empties the chain and expands the zero key.
// When the receiver stalls, each cell holds its word; ready is combinational
// back through the chain, so bubbles fill before req_chan stalls.
module aes128_block_cipher_core (
   input  logic         clock,
   input  logic         reset,
   aes128_req_if.sink   req_chan,
   aes128_rsp_if.source rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready
);

   localparam int R = aes128_pkg::ROUNDS;

   logic [63:0]              key_high_ff, key_low_ff;
   logic                     cfg_wr;
   logic                     ks_busy;
   aes128_pkg::rk_array_type rk;

   // chain taps: index 0 is the initial key-add stage, i is round cell i
   logic                  tap_valid [0:R];
   logic                  tap_op    [0:R];
   aes128_pkg::block_type tap_block [0:R];
   logic                  tap_ready [0:R+1];

   logic                  s0_valid_ff;
   logic                  s0_op_ff;
   aes128_pkg::block_type s0_block_ff;
   aes128_pkg::block_type s0_in;

   // CSR: the register is picked by address bit 3
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[3] == aes128_pkg::REG_KEY_LOW) ? key_low_ff : key_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (cfg_wr) begin
         if (paddr[3] == aes128_pkg::REG_KEY_HIGH) begin
            key_high_ff <= pwdata;
         end else begin
            key_low_ff <= pwdata;
         end
      end
   end

   aes128_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (cfg_wr),
      .key        ({key_high_ff, key_low_ff}),
      .busy       (ks_busy),
      .round_keys (rk)
   );

   // initial AddRoundKey: round 0 key to encrypt, last round key to decrypt
   assign tap_ready[0]   = (!s0_valid_ff || tap_ready[1]) && !ks_busy && !cfg_wr;
   assign req_chan.ready = tap_ready[0];
   assign s0_in = {req_chan.data_high, req_chan.data_low} ^ (req_chan.op ? rk[R] : rk[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (!s0_valid_ff || tap_ready[1]) begin
         s0_valid_ff <= req_chan.valid && tap_ready[0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && tap_ready[0]) begin
         s0_op_ff    <= req_chan.op;
         s0_block_ff <= s0_in;
      end
   end

   assign tap_valid[0] = s0_valid_ff;
   assign tap_op[0]    = s0_op_ff;
   assign tap_block[0] = s0_block_ff;

   // round cells; cell i uses key i to encrypt and key R-i to decrypt
   for (genvar i = 1; i <= R; i++) begin : g_round
      aes128_round_cell #(
         .LAST (i == R)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (tap_valid[i-1]),
         .in_op     (tap_op[i-1]),
         .in_block  (tap_block[i-1]),
         .in_ready  (tap_ready[i]),
         .out_valid (tap_valid[i]),
         .out_op    (tap_op[i]),
         .out_block (tap_block[i]),
         .out_ready (tap_ready[i+1]),
         .enc_key   (rk[i]),
         .dec_key   (rk[R-i])
      );
   end

   // last cell register doubles as the output register
   assign tap_ready[R+1]       = rsp_chan.ready;
   assign rsp_chan.valid       = tap_valid[R];
   assign rsp_chan.result_high = tap_block[R][127:64];
   assign rsp_chan.result_low  = tap_block[R][63:0];

endmodule

[hdl/aes128_key_sched.sv]
module aes128_key_sched (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  aes128_pkg::block_type       key,
   output logic                        busy,
   output aes128_pkg::rk_array_type    round_keys
);

   logic [aes128_pkg::CNT_W-1:0] cnt_ff;
   logic                         busy_ff;
   logic [7:0]                   rcon_ff;
   aes128_pkg::block_type        prev_ff;
   aes128_pkg::rk_array_type     rk_ff;

   logic [31:0]                  rot, sub;
   aes128_pkg::block_type        next_in;

   always_comb begin
      rot = {prev_ff[23:0], prev_ff[31:24]};
      for (int k = 0; k < 4; k++) begin
         sub[31-8*k -: 8] = aes128_pkg::FWD_SBOX[rot[31-8*k -: 8]];
      end
      next_in[127:96] = prev_ff[127:96] ^ sub ^ {rcon_ff, 24'h000000};
      next_in[95:64]  = prev_ff[95:64] ^ next_in[127:96];
      next_in[63:32]  = prev_ff[63:32] ^ next_in[95:64];
      next_in[31:0]   = prev_ff[31:0]  ^ next_in[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == aes128_pkg::CNT_W'(aes128_pkg::ROUNDS)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // one round key per cycle, chained through prev_ff
   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         if (cnt_ff == '0) begin
            rk_ff[0] <= key;
            prev_ff  <= key;
            rcon_ff  <= aes128_pkg::RCON_FIRST;
         end else begin
            rk_ff[cnt_ff] <= next_in;
            prev_ff       <= next_in;
            rcon_ff       <= aes128_pkg::xtime(rcon_ff);
         end
      end
   end

   assign busy       = busy_ff;
   assign round_keys = rk_ff;

endmodule

[hdl/aes128_round_cell.sv]
module aes128_round_cell #(
   parameter bit LAST = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_op,
   input  aes128_pkg::block_type in_block,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic                  out_op,
   output aes128_pkg::block_type out_block,
   input  logic                  out_ready,
   input  aes128_pkg::block_type enc_key,
   input  aes128_pkg::block_type dec_key
);

   logic                  valid_ff;
   logic                  op_ff;
   aes128_pkg::block_type block_ff;
   aes128_pkg::block_type enc_mid, dec_mid, block_in;

   always_comb begin
      enc_mid = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(in_block, 1'b0), 1'b0);
      if (!LAST) begin
         enc_mid = aes128_pkg::mix_columns(enc_mid, 1'b0);
      end
      enc_mid = enc_mid ^ enc_key;

      dec_mid = aes128_pkg::sub_bytes(aes128_pkg::shift_rows(in_block, 1'b1), 1'b1) ^ dec_key;
      if (!LAST) begin
         dec_mid = aes128_pkg::mix_columns(dec_mid, 1'b1);
      end
      block_in = in_op ? dec_mid : enc_mid;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         op_ff    <= in_op;
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_block = block_ff;

endmodule
